>>> sv/jcfe_pkg.sv
// Shared types and character codes for the JSON command frame extractor.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package jcfe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_START = 3'd1,
    ST_BYTE  = 3'd2,
    ST_END   = 3'd3,
    ST_ABORT = 3'd4
  } status_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam int unsigned LEN_W = 12;
  localparam int unsigned POS_W = 11;

endpackage

>>> sv/jcfe_if.sv
// Valid/ready channel interfaces: received bytes in, per-byte status out.
// Depends on jcfe_pkg for the status type.
`timescale 1ns / 1ps

interface jcfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface jcfe_result_if;
  logic                            valid;
  logic                            ready;
  jcfe_pkg::status_t               status;
  logic [7:0]                      out_byte;
  logic [jcfe_pkg::POS_W-1:0]      frame_position;

  modport source (output valid, output status, output out_byte, output frame_position,
                  input ready);
  modport sink   (input valid, input status, input out_byte, input frame_position,
                  output ready);
endinterface

>>> sv/json_command_frame_extractor.sv
// Top level of the JSON command frame extractor: header search, depth tracking, output buffer.
// Depends on jcfe_pkg and the channel interfaces in jcfe_if.sv.
`timescale 1ns / 1ps

// Takes one byte per clock while data.ready is high and returns one status request per byte,
// through the result register, in order. Frames open with {"+ (the '+' reports frame start at
// position 2) and close when the brace depth returns to zero; overlong frames, brackets still
// open at the close and a stray '+' inside a frame report abort. Throughput is one byte per
// cycle: the state update is a single pass of compares and 12-bit/8-bit counters. A two-entry
// output buffer (result register plus skid register) keeps the input ready for one more byte
// while a result waits; data.ready drops only when both entries are full. The user writes
// max_frame_len (cfg_wen/cfg_wdata) only while no byte is in flight; unenforced by the block.
module json_command_frame_extractor #(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic                        clk,
  input  logic                        rst,
  jcfe_byte_if.sink                   data,
  jcfe_result_if.source               result,
  input  logic                        cfg_wen,
  input  logic [jcfe_pkg::LEN_W-1:0]  cfg_wdata
);

  localparam logic [jcfe_pkg::LEN_W-1:0] MAX_LIM =
    (MAX_FRAME > 4095) ? {jcfe_pkg::LEN_W{1'b1}} : jcfe_pkg::LEN_W'(MAX_FRAME);

  logic [jcfe_pkg::LEN_W-1:0] max_frame_len;

  logic                       in_frame;
  logic [jcfe_pkg::LEN_W-1:0] frame_length;
  logic [7:0]                 brace_depth;
  logic [7:0]                 bracket_depth;
  logic [7:0]                 last_byte;
  logic [7:0]                 second_last_byte;
  logic [1:0]                 history_count;

  logic                       in_frame_next;
  logic [jcfe_pkg::LEN_W-1:0] frame_length_next;
  logic [7:0]                 brace_depth_next;
  logic [7:0]                 bracket_depth_next;
  logic [7:0]                 last_byte_next;
  logic [7:0]                 second_last_byte_next;
  logic [1:0]                 history_count_next;

  jcfe_pkg::status_t          st_calc;
  logic [jcfe_pkg::POS_W-1:0] pos_calc;
  logic [jcfe_pkg::LEN_W-1:0] limit;
  logic                       header_match;
  logic [jcfe_pkg::LEN_W-1:0] len_inc;

  logic                       skid_valid;
  jcfe_pkg::status_t          skid_status;
  logic [7:0]                 skid_byte;
  logic [jcfe_pkg::POS_W-1:0] skid_pos;

  logic                       in_fire;
  logic                       out_fire;

  assign data.ready = !skid_valid;
  assign in_fire    = data.valid && data.ready;
  assign out_fire   = result.valid && result.ready;
  assign limit      = (max_frame_len < MAX_LIM) ? max_frame_len : MAX_LIM;

  always_comb begin
    header_match = (data.data_byte == jcfe_pkg::CH_PLUS) && (history_count == 2'd2) &&
                   (second_last_byte == jcfe_pkg::CH_LBRACE) &&
                   (last_byte == jcfe_pkg::CH_QUOTE);

    in_frame_next         = in_frame;
    frame_length_next     = frame_length;
    brace_depth_next      = brace_depth;
    bracket_depth_next    = bracket_depth;
    last_byte_next        = last_byte;
    second_last_byte_next = second_last_byte;
    history_count_next    = history_count;
    st_calc               = jcfe_pkg::ST_IDLE;
    pos_calc              = '0;
    len_inc               = '0;

    if (data.data_byte == jcfe_pkg::CH_PLUS) begin
      if (header_match) begin
        in_frame_next      = 1'b1;
        frame_length_next  = jcfe_pkg::LEN_W'(2);
        brace_depth_next   = 8'd1;
        bracket_depth_next = 8'd0;
      end else if (in_frame) begin
        // stray plus: drop the frame and restart the history from this byte
        st_calc               = jcfe_pkg::ST_ABORT;
        pos_calc              = frame_length[jcfe_pkg::POS_W-1:0];
        in_frame_next         = 1'b0;
        frame_length_next     = '0;
        brace_depth_next      = '0;
        bracket_depth_next    = '0;
        last_byte_next        = '0;
        second_last_byte_next = '0;
        history_count_next    = 2'd0;
      end
    end

    // shift the byte into the history window
    second_last_byte_next = last_byte_next;
    last_byte_next        = data.data_byte;
    if (history_count_next != 2'd2) begin
      history_count_next = history_count_next + 2'd1;
    end

    if (in_frame_next) begin
      unique case (data.data_byte)
        jcfe_pkg::CH_LBRACE: brace_depth_next   = brace_depth_next + 8'd1;
        jcfe_pkg::CH_RBRACE: brace_depth_next   = brace_depth_next - 8'd1;
        jcfe_pkg::CH_LBRACK: bracket_depth_next = bracket_depth_next + 8'd1;
        jcfe_pkg::CH_RBRACK: bracket_depth_next = bracket_depth_next - 8'd1;
        default: ;
      endcase

      pos_calc = frame_length_next[jcfe_pkg::POS_W-1:0];
      len_inc  = frame_length_next + jcfe_pkg::LEN_W'(1);

      if ((len_inc >= limit) || (brace_depth_next == 8'd0 && bracket_depth_next != 8'd0) ||
          (brace_depth_next == 8'd0)) begin
        if ((len_inc >= limit) || (bracket_depth_next != 8'd0 && brace_depth_next == 8'd0)) begin
          st_calc = jcfe_pkg::ST_ABORT;
        end else begin
          st_calc = jcfe_pkg::ST_END;
        end
        in_frame_next         = 1'b0;
        frame_length_next     = '0;
        brace_depth_next      = '0;
        bracket_depth_next    = '0;
        last_byte_next        = '0;
        second_last_byte_next = '0;
        history_count_next    = 2'd0;
      end else begin
        st_calc           = header_match ? jcfe_pkg::ST_START : jcfe_pkg::ST_BYTE;
        frame_length_next = len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len    <= MAX_LIM;
      in_frame         <= 1'b0;
      frame_length     <= '0;
      brace_depth      <= '0;
      bracket_depth    <= '0;
      last_byte        <= '0;
      second_last_byte <= '0;
      history_count    <= 2'd0;
    end else begin
      if (cfg_wen) begin
        max_frame_len <= cfg_wdata;
      end
      if (in_fire) begin
        in_frame         <= in_frame_next;
        frame_length     <= frame_length_next;
        brace_depth      <= brace_depth_next;
        bracket_depth    <= bracket_depth_next;
        last_byte        <= last_byte_next;
        second_last_byte <= second_last_byte_next;
        history_count    <= history_count_next;
      end
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result.valid || out_fire) begin
      if (skid_valid) begin
        result.valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result.valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result.valid || out_fire) begin
      if (skid_valid) begin
        result.status         <= skid_status;
        result.out_byte       <= skid_byte;
        result.frame_position <= skid_pos;
      end else if (in_fire) begin
        result.status         <= st_calc;
        result.out_byte       <= data.data_byte;
        result.frame_position <= pos_calc;
      end
    end else if (in_fire) begin
      skid_status <= st_calc;
      skid_byte   <= data.data_byte;
      skid_pos    <= pos_calc;
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result.valid)
    else $error("skid entry holds a request while the result register is empty");

  a_open_frame_depth: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (brace_depth != 8'd0) && (frame_length >= jcfe_pkg::LEN_W'(3)))
    else $error("open frame with zero brace depth or short length");

  a_closed_frame_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (frame_length == '0) && (brace_depth == 8'd0) && (bracket_depth == 8'd0))
    else $error("frame counters not cleared outside a frame");

  a_history_bound: assert property (@(posedge clk) disable iff (rst)
    history_count != 2'd3)
    else $error("history count beyond two bytes");

  a_idle_position: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == jcfe_pkg::ST_IDLE) |-> (result.frame_position == '0))
    else $error("idle status with nonzero frame position");

endmodule

>>> tb/tb_json_command_frame_extractor.sv
// Self-checking testbench for json_command_frame_extractor: random and directed byte streams,
// a bit-accurate status predictor, random idling on both channels and limit changes.
// Depends on jcfe_pkg, jcfe_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_json_command_frame_extractor;

  localparam int unsigned MAX_FRAME_LEN = 2048;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BYTES  = 100;   // per limit setting

  typedef struct packed {
    jcfe_pkg::status_t                status;
    logic [7:0]                       out_byte;
    logic [jcfe_pkg::POS_W-1:0]       frame_position;
  } status_req_t;

  typedef enum int {
    SEQ_WELL, SEQ_NOISE, SEQ_TRUNC, SEQ_OPEN_BRACKET, SEQ_STRAY_PLUS, SEQ_RESTART,
    SEQ_OVERFLOW, SEQ_BRACE_WRAP
  } seq_kind_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wen;
  logic [jcfe_pkg::LEN_W-1:0] cfg_wdata;

  jcfe_byte_if   data ();
  jcfe_result_if result ();

  json_command_frame_extractor u_dut (
    .clk       (clk),
    .rst       (rst),
    .data      (data),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [jcfe_pkg::LEN_W-1:0] max_len;
  logic                       frm_open;
  logic [jcfe_pkg::LEN_W-1:0] frm_len;
  logic [7:0]                 brace_lvl;
  logic [7:0]                 brack_lvl;
  logic [7:0]                 prev1;
  logic [7:0]                 prev2;
  logic [1:0]                 hist_cnt;

  logic [7:0]  pending_bytes [$];
  status_req_t expected_status [$];
  int unsigned err_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic void push_hist(input logic [7:0] b);
    prev2 = prev1;
    prev1 = b;
    if (hist_cnt < 2'd2) hist_cnt = hist_cnt + 2'd1;
  endfunction

  function automatic void close_frame();
    frm_open  = 1'b0;
    frm_len   = '0;
    brace_lvl = '0;
    brack_lvl = '0;
    prev1     = '0;
    prev2     = '0;
    hist_cnt  = '0;
  endfunction

  function automatic status_req_t scan_byte(input logic [7:0] b);
    status_req_t                r;
    logic                       opened;
    logic [jcfe_pkg::LEN_W-1:0] lim;
    r.status         = jcfe_pkg::ST_IDLE;
    r.out_byte       = b;
    r.frame_position = '0;
    opened           = 1'b0;
    lim = (max_len > MAX_FRAME_LEN) ? jcfe_pkg::LEN_W'(MAX_FRAME_LEN) : max_len;

    if (b == jcfe_pkg::CH_PLUS) begin
      if (hist_cnt == 2'd2 && prev2 == jcfe_pkg::CH_LBRACE && prev1 == jcfe_pkg::CH_QUOTE) begin
        // open, or silently restart, a frame
        frm_open  = 1'b1;
        frm_len   = jcfe_pkg::LEN_W'(2);
        brace_lvl = 8'd1;
        brack_lvl = 8'd0;
        opened    = 1'b1;
      end else if (frm_open) begin
        r.status         = jcfe_pkg::ST_ABORT;
        r.frame_position = frm_len[jcfe_pkg::POS_W-1:0];
        close_frame();
      end
    end

    if (frm_open) begin
      case (b)
        jcfe_pkg::CH_LBRACE: brace_lvl = brace_lvl + 8'd1;
        jcfe_pkg::CH_RBRACE: brace_lvl = brace_lvl - 8'd1;
        jcfe_pkg::CH_LBRACK: brack_lvl = brack_lvl + 8'd1;
        jcfe_pkg::CH_RBRACK: brack_lvl = brack_lvl - 8'd1;
        default: ;
      endcase
      r.frame_position = frm_len[jcfe_pkg::POS_W-1:0];
      frm_len = frm_len + jcfe_pkg::LEN_W'(1);
      push_hist(b);
      if (frm_len >= lim || (brace_lvl == 8'd0 && brack_lvl != 8'd0)) begin
        r.status = jcfe_pkg::ST_ABORT;
        close_frame();
      end else if (brace_lvl == 8'd0) begin
        r.status = jcfe_pkg::ST_END;
        close_frame();
      end else begin
        r.status = opened ? jcfe_pkg::ST_START : jcfe_pkg::ST_BYTE;
      end
    end else begin
      push_hist(b);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // stimulus builders
  function automatic void put(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_cnt++;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == jcfe_pkg::CH_PLUS || b == jcfe_pkg::CH_LBRACE || b == jcfe_pkg::CH_RBRACE ||
           b == jcfe_pkg::CH_LBRACK || b == jcfe_pkg::CH_RBRACK);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, 255));
      4: return jcfe_pkg::CH_PLUS;
      5: return jcfe_pkg::CH_QUOTE;
      6: return jcfe_pkg::CH_LBRACE;
      7: return jcfe_pkg::CH_RBRACE;
      8: return jcfe_pkg::CH_LBRACK;
      default: return jcfe_pkg::CH_RBRACK;
    endcase
  endfunction

  function automatic void put_header();
    put(jcfe_pkg::CH_LBRACE);
    put(jcfe_pkg::CH_QUOTE);
    put(jcfe_pkg::CH_PLUS);
  endfunction

  function automatic void put_sequence(input seq_kind_t kind);
    logic [7:0]  closers [$];
    int unsigned n;
    int unsigned lim;
    lim = (max_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : max_len;
    if (kind == SEQ_NOISE) begin
      n = $urandom_range(1, 30);
      repeat (n) put(noise_byte());
      return;
    end
    // a little lead-in so the header lands at every offset of the history
    repeat ($urandom_range(0, 2)) put(noise_byte());
    put_header();
    if (kind == SEQ_OVERFLOW) begin
      repeat (lim) put(plain_byte());
      return;
    end
    if (kind == SEQ_BRACE_WRAP) begin
      repeat (255) put(jcfe_pkg::CH_LBRACE);
      return;
    end
    n = $urandom_range(0, 24);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2 && kind == SEQ_STRAY_PLUS) put(jcfe_pkg::CH_PLUS);
      if (i == n / 2 && kind == SEQ_RESTART) begin
        put(jcfe_pkg::CH_LBRACE);
        put(jcfe_pkg::CH_QUOTE);
        put(jcfe_pkg::CH_PLUS);
        closers.delete();
      end
      case ($urandom_range(0, 9))
        0: if (closers.size() < 6) begin
          put(jcfe_pkg::CH_LBRACE);
          closers.push_back(jcfe_pkg::CH_RBRACE);
        end
        1: if (closers.size() < 6) begin
          put(jcfe_pkg::CH_LBRACK);
          closers.push_back(jcfe_pkg::CH_RBRACK);
        end
        2: if (closers.size() > 0) put(closers.pop_back());
        default: put(plain_byte());
      endcase
    end
    if (kind == SEQ_TRUNC) return;
    if (kind == SEQ_OPEN_BRACKET) put(jcfe_pkg::CH_LBRACK);
    while (closers.size() > 0) put(closers.pop_back());
    put(jcfe_pkg::CH_RBRACE);
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || data.valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [jcfe_pkg::LEN_W-1:0] v);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    max_len = v;
  endtask

  // byte driver
  logic        src_calm = 1'b0;
  int unsigned gap_cnt;

  always @(posedge clk) begin
    if (rst) begin
      data.valid     <= 1'b0;
      data.data_byte <= '0;
      gap_cnt        <= 0;
    end else begin
      if (data.valid && data.ready)
        expected_status.push_back(scan_byte(data.data_byte));
      if (data.valid && !data.ready) begin
        // hold the request until the block takes it
      end else if (gap_cnt != 0) begin
        data.valid <= 1'b0;
        gap_cnt    <= gap_cnt - 1;
      end else if (pending_bytes.size() != 0) begin
        data.valid     <= 1'b1;
        data.data_byte <= pending_bytes.pop_front();
        gap_cnt        <= src_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 63) == 0) src_calm <= !src_calm;
      end else begin
        data.valid <= 1'b0;
      end
    end
  end

  // status monitor and checker
  logic        sink_calm = 1'b0;
  int unsigned stall_cnt;

  always @(posedge clk) begin
    int unsigned hold;
    status_req_t got;
    status_req_t want;
    if (rst) begin
      result.ready <= 1'b0;
      stall_cnt    <= 0;
    end else begin
      if (result.valid && result.ready) begin
        got.status         = result.status;
        got.out_byte       = result.out_byte;
        got.frame_position = result.frame_position;
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("status request with none expected: status %0d byte %02h",
                                    got.status, got.out_byte));
        end else begin
          want = expected_status.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (byte %02h)",
                                      got.status, want.status, want.out_byte));
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
          if (got.frame_position !== want.frame_position)
            report_mismatch($sformatf("frame_position %0d, expected %0d (byte %02h)",
                                      got.frame_position, want.frame_position,
                                      want.out_byte));
        end
      end
      if (stall_cnt != 0) begin
        result.ready <= 1'b0;
        stall_cnt    <= stall_cnt - 1;
      end else if (result.valid && result.ready) begin
        hold = sink_calm ? 0 : $urandom_range(0, 6);
        result.ready <= (hold == 0);
        stall_cnt    <= (hold == 0) ? 0 : hold - 1;
        if ($urandom_range(0, 63) == 0) sink_calm <= !sink_calm;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("json_command_frame_extractor test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]                 opening [$];
    logic [jcfe_pkg::LEN_W-1:0] limits [$];
    int unsigned                mark;
    int unsigned                k;
    seq_kind_t                  kind;

    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    max_len   = jcfe_pkg::LEN_W'(MAX_FRAME_LEN);
    close_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes, stray plus while idle, a clean frame, stray plus in a frame,
    // restart inside a frame, then brackets left open at the close
    opening = '{8'h00, 8'hFF, 8'h80, 8'h7F, jcfe_pkg::CH_PLUS,
                jcfe_pkg::CH_LBRACE, jcfe_pkg::CH_QUOTE, jcfe_pkg::CH_PLUS,
                jcfe_pkg::CH_LBRACK, jcfe_pkg::CH_RBRACK, jcfe_pkg::CH_RBRACE,
                jcfe_pkg::CH_LBRACE, jcfe_pkg::CH_QUOTE, jcfe_pkg::CH_PLUS, 8'h61,
                jcfe_pkg::CH_PLUS,
                jcfe_pkg::CH_LBRACE, jcfe_pkg::CH_QUOTE, jcfe_pkg::CH_PLUS,
                jcfe_pkg::CH_LBRACE, jcfe_pkg::CH_QUOTE, jcfe_pkg::CH_PLUS,
                jcfe_pkg::CH_LBRACK, jcfe_pkg::CH_RBRACE};
    write_limit(jcfe_pkg::LEN_W'(MAX_FRAME_LEN));
    foreach (opening[i]) put(opening[i]);

    limits = '{12'd4, 12'd3, 12'd12, 12'd40, 12'd300, 12'd4095, 12'd2048, 12'd5};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (max_len == 12'd300) begin
        put_sequence(SEQ_BRACE_WRAP);
        put_sequence(SEQ_OVERFLOW);
      end
      mark = queued_cnt;
      while (queued_cnt - mark < RANDOM_BYTES) begin
        k = $urandom_range(0, 99);
        if (k < 55)      kind = SEQ_WELL;
        else if (k < 65) kind = SEQ_NOISE;
        else if (k < 72) kind = SEQ_TRUNC;
        else if (k < 80) kind = SEQ_OPEN_BRACKET;
        else if (k < 88) kind = SEQ_STRAY_PLUS;
        else if (k < 95) kind = SEQ_RESTART;
        else             kind = (max_len <= 12'd64) ? SEQ_OVERFLOW : SEQ_WELL;
        put_sequence(kind);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("json_command_frame_extractor test passed");
    else
      $display("json_command_frame_extractor test failed");
    $finish;
  end

endmodule
